@@ rtl/core/chained_block_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chained block allocator unit.
// Each macro expands to one labelled concurrent assertion on clk_i.
// ----------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define CHAINED_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Checked only outside reset.
`define CBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/cba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained block allocator package
// Sizes, codes and transaction types shared by the allocator modules.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int unsigned NUM_BLOCKS = 256;
  localparam int unsigned ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned LINK_W     = 9;

  localparam logic [LINK_W-1:0] CHAIN_END = {LINK_W{1'b1}};

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTUSED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_TAIL,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e              opcode;
    logic [8:0]       block_count;
    logic [ID_W-1:0]  file_id;
    logic [7:0]       start_block;
  } req_t;

  typedef struct packed {
    logic [7:0]       first_block;
    status_e          status;
    logic [8:0]       blocks_changed;
    logic [8:0]       free_blocks;
  } rsp_t;

  // One table entry: used mark, owner tag and link to the next block.
  typedef struct packed {
    logic              used;
    logic [ID_W-1:0]   owner;
    logic [LINK_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

endpackage

@@ rtl/core/cba_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained block allocator table
// Block table memory with one read and one write port, registered read data
// and a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cba_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cba_pkg::mem_req_t req_i,
  output cba_pkg::entry_t   rd_data_o
);
  import cba_pkg::*;

  entry_t                mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;
  entry_t                rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/core/cba_engine.sv @@
`timescale 1ns / 1ps
`include "chained_block_allocator_unit_assert.svh"
// ----------------------------------------------------------------------------
// Chained block allocator engine
// Sequencer that scans the table for free blocks or walks a chain, at most
// one table read and at most one table write per cycle.
// ----------------------------------------------------------------------------
module cba_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cba_pkg::req_t     in_data_i,
  output logic              in_stall_o,
  output logic              res_valid_o,
  output cba_pkg::rsp_t     res_data_o,
  input  logic              res_ready_i,
  output cba_pkg::mem_req_t mem_req_o,
  input  cba_pkg::entry_t   mem_rsp_i
);
  import cba_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  want_q, want_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              dat_vld_q;
  logic [ADDR_W-1:0] dat_addr_q;
  logic [ADDR_W-1:0] prev_q, prev_d;
  logic [ADDR_W-1:0] first_q, first_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  free_q, free_d;
  status_e           status_q, status_d;
  logic              head_q, head_d;

  logic             accept;
  logic             too_many;
  logic             claim;
  logic             last_claim;
  logic             link_go;
  logic [CNT_W-1:0] cnt_inc;

  logic             free_ok;
  logic             rw_clash;
  logic             nospace_rsp;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign too_many   = in_data_i.block_count > free_q;
  assign cnt_inc    = CNT_W'(cnt_q + CNT_W'(1));
  assign claim      = dat_vld_q && !mem_rsp_i.used;
  assign last_claim = claim && (cnt_inc == want_q);
  assign link_go    = (mem_rsp_i.link < LINK_W'(NUM_BLOCKS))
                   && (mem_rsp_i.link[ADDR_W-1:0] != dat_addr_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.opcode == OP_FREE) begin
            state_d = S_FREE;
          end else if (too_many || (in_data_i.block_count == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if (last_claim) begin
          state_d = S_TAIL;
        end else if (!dat_vld_q && iss_q[ADDR_W]) begin
          state_d = S_DONE;
        end
      end
      S_TAIL: state_d = S_DONE;
      S_FREE: begin
        if (dat_vld_q && (!mem_rsp_i.used || !link_go)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: handshake and table accesses.
  always_comb begin
    mem_req_o   = '0;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          if (in_data_i.opcode == OP_FREE) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = in_data_i.start_block;
          end else if (!too_many && (in_data_i.block_count != '0)) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = '0;
          end
        end
      end
      S_ALLOC: begin
        mem_req_o.rd_en   = !iss_q[ADDR_W];
        mem_req_o.rd_addr = iss_q[ADDR_W-1:0];
        if (claim && (cnt_q != '0)) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = prev_q;
          mem_req_o.wr_data = '{used: 1'b1, owner: id_q,
                                link: LINK_W'(dat_addr_q)};
        end
      end
      S_TAIL: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = prev_q;
        mem_req_o.wr_data = '{used: 1'b1, owner: id_q, link: CHAIN_END};
      end
      S_FREE: begin
        if (dat_vld_q && mem_rsp_i.used) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = dat_addr_q;
          mem_req_o.wr_data = '0;
          if (link_go) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = mem_rsp_i.link[ADDR_W-1:0];
          end
        end
      end
      S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    want_d   = want_q;
    id_d     = id_q;
    iss_d    = iss_q;
    prev_d   = prev_q;
    first_d  = first_q;
    cnt_d    = cnt_q;
    free_d   = free_q;
    status_d = status_q;
    head_d   = head_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          want_d   = in_data_i.block_count;
          id_d     = in_data_i.file_id;
          iss_d    = CNT_W'(1);
          first_d  = '0;
          cnt_d    = '0;
          head_d   = 1'b1;
          status_d = ((in_data_i.opcode == OP_ALLOC) && too_many) ? ST_NOSPACE : ST_OK;
        end
      end
      S_ALLOC: begin
        if (!iss_q[ADDR_W]) begin
          iss_d = CNT_W'(iss_q + CNT_W'(1));
        end
        if (claim) begin
          if (cnt_q == '0) begin
            first_d = dat_addr_q;
          end
          prev_d = dat_addr_q;
          cnt_d  = cnt_inc;
          free_d = CNT_W'(free_q - CNT_W'(1));
        end
      end
      S_FREE: begin
        if (dat_vld_q) begin
          head_d = 1'b0;
          if (mem_rsp_i.used) begin
            cnt_d  = cnt_inc;
            free_d = CNT_W'(free_q + CNT_W'(1));
          end else if (head_q) begin
            status_d = ST_NOTUSED;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      free_q    <= CNT_W'(NUM_BLOCKS);
      dat_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      dat_vld_q <= mem_req_o.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q     <= want_d;
    id_q       <= id_d;
    iss_q      <= iss_d;
    dat_addr_q <= mem_req_o.rd_addr;
    prev_q     <= prev_d;
    first_q    <= first_d;
    cnt_q      <= cnt_d;
    status_q   <= status_d;
    head_q     <= head_d;
  end

  assign res_data_o = '{first_block: first_q, status: status_q,
                        blocks_changed: cnt_q, free_blocks: free_q};

  assign free_ok     = free_q <= CNT_W'(NUM_BLOCKS);
  assign rw_clash    = mem_req_o.rd_en && mem_req_o.wr_en
                    && (mem_req_o.rd_addr == mem_req_o.wr_addr);
  assign nospace_rsp = res_valid_o && (status_q == ST_NOSPACE);

  `CBA_ASSERT_ALWAYS(a_free_bound, !rst_ni || free_ok, "free count above pool size")
  `CBA_ASSERT(a_no_rw_clash, !rw_clash, "read and write of one entry in one cycle")
  `CBA_ASSERT(a_nospace_empty, nospace_rsp |-> (cnt_q == '0), "refused allocate changed blocks")
  `CBA_ASSERT(a_tail_after_claim, (state_q == S_TAIL) |-> (cnt_q == want_q), "chain closed early")

endmodule

@@ rtl/core/chained_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained block allocator unit
// File-allocation-table engine: allocates linked chains of blocks from a
// fixed pool and frees them again by walking their links.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+----------------------------
//  in       | input     | in_valid_i/in_stall_o | cba_pkg::req_t request
//  out      | output    | out_valid_o/out_stall_i | cba_pkg::rsp_t response
//
// An allocate occupies the engine while it scans from block 0 up to the last
// block it claims and closes the chain; a free, while it walks the chain.
// Both are set by the single read port of the block table, which is visited
// one entry per cycle. A refused or empty request reaches its response with
// no table scan. Reset clears the table at once through per-entry valid bits,
// so there is no clearing pass. A stalled response sits in the output
// register while the next request is already being worked on.
// ----------------------------------------------------------------------------
module chained_block_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cba_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cba_pkg::rsp_t  out_data_o
);
  import cba_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rsp;
  logic     res_valid;
  logic     res_ready;
  rsp_t     res_data;

  logic     out_vld_q, out_vld_d;
  rsp_t     out_q;

  // The engine owns the sequencing; the table holds owner, used mark and
  // link of every block in a single memory.
  cba_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp)
  );

  cba_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rsp)
  );

  // Output register: the engine hands over a response whenever the register
  // is empty or its current transaction leaves in this cycle.
  assign res_ready = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/chained_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the chained block allocator unit
// Sends allocate and free transactions into the block and checks every
// response, field by field, against a predictor that keeps its own copy of
// the block table. Directed transactions come first, then a back-pressure
// test, then several phases of random traffic with varying idle patterns.
// ----------------------------------------------------------------------------
module chained_block_allocator_unit_tb;
  import cba_pkg::*;

  // Timeout, counted in clock cycles from the start of the run. It lies above
  // the slowest correct run (every allocate scanning the whole pool, every
  // response held back by the longest receiver stall).
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // Cycles to wait once nothing is outstanding, to catch any stray response.
  localparam int unsigned SETTLE_CYCLES = 300;

  // Number of random transactions in each random phase.
  localparam int unsigned PHASE_ITEMS = 170;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid;
  logic  in_stall;
  req_t  in_data;
  logic  out_valid;
  logic  out_stall;
  rsp_t  out_data;

  chained_block_allocator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // --------------------------------------------------------------------------
  // Clock: 2 ns period.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the block table. It is updated in the order in which the
  // block accepts transactions, so it always matches what the block should
  // hold once every accepted transaction has been worked through.
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]   blk_owner [NUM_BLOCKS];
  logic              blk_used  [NUM_BLOCKS];
  logic [LINK_W-1:0] blk_link  [NUM_BLOCKS];
  int unsigned       pool_free;

  // Responses still owed by the block, oldest first.
  rsp_t expected_rsp[$];

  // First blocks of chains that were handed out, used to build well-formed
  // free transactions in the random phases.
  logic [7:0] chain_heads[$];

  // Knobs for the idle behaviour of both sides. A gap_max of zero means the
  // sender never drops valid between transactions.
  int unsigned burst_max;
  int unsigned gap_max;
  int unsigned burst_left;
  int unsigned stall_pct;
  int unsigned hold_request;

  // Bookkeeping for the summary and the verdict.
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned n_alloc;
  int unsigned n_free;
  int unsigned n_refused;
  int unsigned n_checked;
  int unsigned stall_run;
  int unsigned longest_stall;

  // Applies one request to the shadow table and works out the response that
  // the block must give for it.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        res;
    int unsigned taken;
    int unsigned prev;
    int unsigned cur;
    int unsigned nxt;
    logic        done;
    res.first_block    = '0;
    res.status         = ST_OK;
    res.blocks_changed = '0;
    taken              = 0;
    prev               = 0;
    if (r.opcode == OP_ALLOC) begin
      if (r.block_count > pool_free) begin
        // Too few free blocks: the table is left alone.
        res.status = ST_NOSPACE;
      end else begin
        // Claim the lowest free blocks and link each to the next; a count of
        // zero claims nothing and still reports success.
        for (int b = 0; b < NUM_BLOCKS && taken < r.block_count; b++) begin
          if (!blk_used[b]) begin
            blk_used[b]  = 1'b1;
            blk_owner[b] = r.file_id;
            blk_link[b]  = CHAIN_END;
            if (taken == 0) begin
              res.first_block = 8'(b);
            end else begin
              blk_link[prev] = LINK_W'(b);
            end
            prev = b;
            taken++;
            pool_free--;
          end
        end
      end
    end else begin
      if (!blk_used[r.start_block]) begin
        res.status = ST_NOTUSED;
      end else begin
        // Walk the chain. The walk ends at the end mark, at a link that leaves
        // the pool or at a link into a block that is no longer in use, so a
        // free from the middle of a chain releases only its tail.
        cur  = r.start_block;
        done = 1'b0;
        while (!done) begin
          nxt            = blk_link[cur];
          blk_owner[cur] = '0;
          blk_used[cur]  = 1'b0;
          blk_link[cur]  = '0;
          pool_free++;
          taken++;
          if (nxt == CHAIN_END || nxt >= NUM_BLOCKS || !blk_used[nxt]) begin
            done = 1'b1;
          end else begin
            cur = nxt;
          end
        end
      end
    end
    res.blocks_changed = 9'(taken);
    res.free_blocks    = 9'(pool_free);
    return res;
  endfunction

  function automatic req_t make_req(input op_e op, input int unsigned count,
                                    input int unsigned id, input int unsigned start);
    req_t r;
    r.opcode      = op;
    r.block_count = 9'(count);
    r.file_id     = ID_W'(id);
    r.start_block = 8'(start);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned exp_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; offers one transaction and holds it
  // until the block takes it. Valid stays high across a burst and drops for
  // a random gap between bursts, unless gap_max is zero.
  // --------------------------------------------------------------------------
  task automatic send_request(input req_t r, output rsp_t predicted);
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
    predicted = apply_request(r);
    expected_rsp.push_back(predicted);
    if (r.opcode == OP_ALLOC) n_alloc++;
    else n_free++;
    if (predicted.status != ST_OK) n_refused++;
    @(negedge clk_i);
    if (gap_max != 0) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
        burst_left = $urandom_range(1, burst_max);
      end
    end
  endtask

  // Drops valid and waits at a falling edge until every owed response has
  // come back.
  task automatic wait_until_settled();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Stalls in runs of random length, with the share of stalled runs
  // set by stall_pct. A hold request overrides this with one long stall.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    logic        run_stalled;
    hold_left   = 0;
    run_left    = 0;
    run_stalled = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (run_left == 0) begin
        run_stalled = ($urandom_range(0, 99) < stall_pct);
        run_left    = $urandom_range(1, 8);
      end
      run_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= run_stalled;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker, cycle counter and input stall monitor, all sampled at
  // the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsp.size());
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && in_valid && in_stall) begin
      stall_run++;
      if (stall_run > longest_stall) longest_stall = stall_run;
    end else begin
      stall_run = 0;
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with nothing outstanding, first_block",
                        out_data.first_block, 0);
      end else begin
        exp_rsp = expected_rsp.pop_front();
        n_checked++;
        if (out_data.first_block !== exp_rsp.first_block)
          report_mismatch("first_block", out_data.first_block, exp_rsp.first_block);
        if (out_data.status !== exp_rsp.status)
          report_mismatch("status", int'(out_data.status), int'(exp_rsp.status));
        if (out_data.blocks_changed !== exp_rsp.blocks_changed)
          report_mismatch("blocks_changed", out_data.blocks_changed,
                          exp_rsp.blocks_changed);
        if (out_data.free_blocks !== exp_rsp.free_blocks)
          report_mismatch("free_blocks", out_data.free_blocks, exp_rsp.free_blocks);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Allocate corner cases on an empty pool: an empty request, the widest
  // and narrowest owner tags, and counts that exceed the free blocks.
  task automatic test_alloc_cases();
    rsp_t res;
    send_request(make_req(OP_ALLOC, 0, 16'h1234, 8'h00), res);
    send_request(make_req(OP_ALLOC, 1, 16'hFFFF, 8'hFF), res);
    // Owner tag zero is carried out like any other tag.
    send_request(make_req(OP_ALLOC, 3, 16'h0000, 8'h00), res);
    send_request(make_req(OP_ALLOC, 511, 16'h00FF, 8'h80), res);
    // One block more than is free.
    send_request(make_req(OP_ALLOC, pool_free + 1, 16'hFF00, 8'h7F), res);
    wait_until_settled();
  endtask

  // Frees from the middle of a chain, of a chain whose next block was freed
  // already, of blocks that are not in use and of a one-block chain. The
  // ignored count field carries all ones in the first two frees only.
  task automatic test_free_cases();
    rsp_t res;
    send_request(make_req(OP_FREE, 511, 16'hFFFF, 2), res);
    send_request(make_req(OP_FREE, 511, 16'h0000, 1), res);
    send_request(make_req(OP_FREE, 0, 16'h5555, 1), res);
    send_request(make_req(OP_FREE, 256, 16'hAAAA, 255), res);
    send_request(make_req(OP_FREE, 0, 16'h0001, 0), res);
    wait_until_settled();
  endtask

  // Fills the whole pool, refuses once it is full, reuses the last block and
  // then frees through a stale link into a chain that reused a block. Ends by
  // freeing a small fragmented layout in which a chain skips two used blocks.
  task automatic test_full_pool();
    rsp_t res;
    send_request(make_req(OP_ALLOC, 256, 16'hA5A5, 0), res);
    send_request(make_req(OP_ALLOC, 1, 16'h0002, 0), res);
    send_request(make_req(OP_ALLOC, 0, 16'h0003, 0), res);
    send_request(make_req(OP_FREE, 0, 0, 255), res);
    send_request(make_req(OP_ALLOC, 1, 16'h5A5A, 0), res);
    send_request(make_req(OP_FREE, 0, 0, 128), res);
    send_request(make_req(OP_FREE, 0, 0, 0), res);
    send_request(make_req(OP_ALLOC, 2, 16'h0001, 0), res);
    send_request(make_req(OP_ALLOC, 2, 16'h0002, 0), res);
    send_request(make_req(OP_FREE, 0, 0, 0), res);
    send_request(make_req(OP_ALLOC, 3, 16'h0003, 0), res);
    send_request(make_req(OP_FREE, 0, 0, 0), res);
    send_request(make_req(OP_FREE, 0, 0, 2), res);
    wait_until_settled();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering short transactions back to back, so that the response register
  // fills and the block stalls its input.
  task automatic test_backpressure();
    rsp_t res;
    stall_pct    = 0;
    gap_max      = 0;
    hold_request = 400;
    for (int i = 0; i < 6; i++)
      send_request(make_req(OP_ALLOC, 1, $urandom_range(1, 65535), 0), res);
    for (int i = 0; i < 6; i++)
      send_request(make_req(OP_FREE, 0, 0, i), res);
    wait_until_settled();
  endtask

  // Random traffic in four phases with different idle patterns: no idling at
  // all, moderate idling, heavy receiver stalls, and long bursts. Most
  // transactions are well formed: small allocations and frees of chains that
  // were handed out. The rest are oversized requests and frees of arbitrary
  // blocks, including the middle of chains and blocks not in use.
  task automatic test_random_traffic();
    req_t        r;
    rsp_t        res;
    int unsigned sel;
    int unsigned pick;
    int unsigned idx;
    int unsigned base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_max = 0; burst_max = 1;  stall_pct = 0;  end
        1: begin gap_max = 8; burst_max = 4;  stall_pct = 30; end
        2: begin gap_max = 3; burst_max = 2;  stall_pct = 70; end
        default: begin gap_max = 5; burst_max = 20; stall_pct = 10; end
      endcase
      burst_left = $urandom_range(1, burst_max);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Ignored fields carry random values throughout.
        r   = make_req(OP_ALLOC, $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        // Lean towards frees when the pool runs low.
        if (pool_free < 24 && sel < 60) sel = 60;
        if (sel < 50) begin
          pick = $urandom_range(0, 19);
          if (pick == 0)      r.block_count = 9'($urandom_range(0, 511));
          else if (pick == 1) r.block_count = 9'(pool_free + $urandom_range(0, 2));
          else if (pick < 4)  r.block_count = 9'($urandom_range(0, pool_free));
          else                r.block_count = 9'($urandom_range(1, 6));
        end else if (sel < 80 && chain_heads.size() != 0) begin
          r.opcode = OP_FREE;
          idx      = $urandom_range(0, chain_heads.size() - 1);
          r.start_block = chain_heads[idx];
          chain_heads.delete(idx);
        end else if (sel < 95) begin
          // Any block in use, which is often in the middle of a chain.
          r.opcode = OP_FREE;
          base     = $urandom_range(0, NUM_BLOCKS - 1);
          for (int k = 0; k < NUM_BLOCKS; k++) begin
            if (blk_used[(base + k) % NUM_BLOCKS]) begin
              r.start_block = 8'((base + k) % NUM_BLOCKS);
              break;
            end
          end
        end else begin
          r.opcode = OP_FREE;
        end
        send_request(r, res);
        if (r.opcode == OP_ALLOC && res.status == ST_OK && res.blocks_changed != 0)
          chain_heads.push_back(res.first_block);
      end
      wait_until_settled();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    errors       = 0;
    cycle_count  = 0;
    n_alloc      = 0;
    n_free       = 0;
    n_refused    = 0;
    n_checked    = 0;
    stall_run    = 0;
    longest_stall = 0;
    hold_request = 0;
    stall_pct    = 0;
    gap_max      = 3;
    burst_max    = 3;
    burst_left   = 1;
    pool_free    = NUM_BLOCKS;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      blk_owner[b] = '0;
      blk_used[b]  = 1'b0;
      blk_link[b]  = '0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_alloc_cases();
    test_free_cases();
    test_full_pool();
    test_backpressure();
    test_random_traffic();

    // Nothing is owed any more; give the block time to show any stray
    // response before the verdict.
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d allocate and %0d free transactions, %0d of them refused,",
             n_alloc, n_free, n_refused);
    $display("with %0d responses checked; longest input stall %0d cycles.",
             n_checked, longest_stall);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d responses never arrived", errors, expected_rsp.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
